// ===== src/malf_pkg.sv =====
package malf_pkg;

    localparam int PATH_MAX_DEF = 64;
    localparam int NUM_TRAINS   = 3;
    localparam int BAL_W        = 8;
    localparam int OFF_W        = 24;

    localparam logic [1:0] OP_PATH  = 2'd0;
    localparam logic [1:0] OP_POS   = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    localparam logic [1:0] STAT_FOUND   = 2'd0;
    localparam logic [1:0] STAT_NO_OWN  = 2'd1;
    localparam logic [1:0] STAT_NO_LAP  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_SPEC = 4'b0100,
        ST_WALK = 4'b1000
    } t_state;

    // Tag of the path entry whose read data shows up this cycle.
    typedef struct packed {
        logic valid;
        logic last;
    } t_tag;

    // Next train around the ring of three.
    function automatic logic [1:0] f_next(input logic [1:0] t);
        logic [1:0] r;
        r = (t == 2'd2) ? 2'd0 : t + 2'd1;
        return r;
    endfunction

endpackage

// ===== src/malf_ram.sv =====
module malf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/malf_walk.sv =====
// Path entry sequencer: while run is high, issue one read a cycle over a
// circular range, tagging the data with its index and whether it is final.
module malf_walk #(
    parameter int PATH_MAX = malf_pkg::PATH_MAX_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  logic [$clog2(PATH_MAX)-1:0]   i_first,
    input  logic [$clog2(PATH_MAX+1)-1:0] i_len,
    input  logic                          i_run,
    output logic                          o_rd_en,
    output logic [$clog2(PATH_MAX)-1:0]   o_rd_idx,
    output malf_pkg::t_tag                o_tag,
    output logic [$clog2(PATH_MAX)-1:0]   o_tag_idx
);

    localparam int IW = $clog2(PATH_MAX);
    localparam int CW = $clog2(PATH_MAX+1);

    logic [IW-1:0]  r_idx;
    logic [CW-1:0]  r_left;
    logic [CW-1:0]  r_len;
    logic           r_valid;
    logic           r_last;
    logic [IW-1:0]  r_tag_idx;
    logic           issue;
    logic           wrap;

    assign issue = i_run && (r_left != '0);
    assign wrap  = ((CW'(r_idx) + CW'(1)) == r_len);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left  <= '0;
            r_valid <= 1'b0;
            r_last  <= 1'b0;
        end else if (i_load) begin
            r_idx   <= i_first;
            r_len   <= i_len;
            r_left  <= i_len;
            r_valid <= 1'b0;
            r_last  <= 1'b0;
        end else begin
            r_valid <= issue;
            r_last  <= issue && (r_left == CW'(1));
            if (issue) begin
                r_tag_idx <= r_idx;
                r_idx     <= wrap ? '0 : r_idx + IW'(1);
                r_left    <= r_left - CW'(1);
            end
        end
    end

    assign o_rd_en     = issue;
    assign o_rd_idx    = r_idx;
    assign o_tag.valid = r_valid;
    assign o_tag.last  = r_last;
    assign o_tag_idx   = r_tag_idx;

endmodule

// ===== src/movement_authority_limit_finder_core.sv =====
// Movement authority limit finder for three trains on circular balise paths.
//
// Command channel: present i_op, i_train and the operand ports with start high;
// the transaction is taken at a rising edge with start high and busy low.
//   path write (i_op 0) and position update (i_op 1) finish in that same cycle
//   and give no result; busy stays low. An unused op code is dropped.
//   query (i_op 2) raises busy while the path is searched.
// Result channel: o_valid is high for exactly one cycle with o_eoa_balise,
// o_eoa_offset and o_status; the receiver cannot stall, so results are never
// held back. A query for a train with no path or an invalid train number
// reports on the cycle after acceptance without going busy.
// Query steps: the scan reads the path from index 0 until the own balise matches,
// the next cycle checks the same-balise cases, and otherwise a walk of one lap
// from the entry after the own one strobes the result where it stops.
// The single read port of the path memory sets the pace: one entry per cycle
// in both the scan and the walk.
// Reset (i_rst_n low, synchronous) clears all path lengths and train positions;
// path memory contents are not cleared and must be written before use.
module movement_authority_limit_finder_core #(
    parameter int PATH_MAX = malf_pkg::PATH_MAX_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        i_op,
    input  logic [1:0]                        i_train,
    input  logic [5:0]                        i_path_index,
    input  logic [6:0]                        i_path_len,
    input  logic [malf_pkg::BAL_W-1:0]        i_balise,
    input  logic signed [malf_pkg::OFF_W-1:0] i_offset,
    input  logic [malf_pkg::BAL_W-1:0]        i_resource_balise,
    output logic                              o_valid,
    output logic [malf_pkg::BAL_W-1:0]        o_eoa_balise,
    output logic signed [malf_pkg::OFF_W-1:0] o_eoa_offset,
    output logic [1:0]                        o_status
);

    localparam int IW    = $clog2(PATH_MAX);
    localparam int CW    = $clog2(PATH_MAX+1);
    localparam int DEPTH = malf_pkg::NUM_TRAINS * PATH_MAX;
    localparam int AW    = $clog2(DEPTH);
    localparam int BW    = malf_pkg::BAL_W;
    localparam int OW    = malf_pkg::OFF_W;

    // Control state
    malf_pkg::t_state r_state, n_state;
    logic [1:0]     r_t;
    logic [BW-1:0]  r_res;
    logic [CW-1:0]  r_len;
    logic [IW-1:0]  r_pos, n_pos;

    // Per-train state
    logic [CW-1:0]         r_path_len [malf_pkg::NUM_TRAINS];
    logic [BW-1:0]         r_tr_bal   [malf_pkg::NUM_TRAINS];
    logic signed [OW-1:0]  r_tr_off   [malf_pkg::NUM_TRAINS];

    // Result register
    logic                  r_ovalid, n_ovalid;
    logic [BW-1:0]         r_obal, n_obal;
    logic signed [OW-1:0]  r_ooff, n_ooff;
    logic [1:0]            r_ostat, n_ostat;

    // Command decode
    logic          accept;
    logic          tr_ok;
    logic          path_ok;
    logic [CW-1:0] len_sat;
    logic [CW-1:0] in_len;

    // Walker and memory hookup
    logic                 w_load;
    logic [IW-1:0]        w_first;
    logic [CW-1:0]        w_len;
    logic                 w_run;
    logic                 rd_en;
    logic [IW-1:0]        rd_idx;
    malf_pkg::t_tag       tag;
    logic [IW-1:0]        tag_idx;
    logic [AW-1:0]        waddr;
    logic [AW-1:0]        raddr;
    logic                 ram_we;
    logic [BW-1:0]        rdata;

    // Query context
    logic [1:0]            t_n1, t_n2;
    logic [BW-1:0]         own_bal, bal1, bal2;
    logic signed [OW-1:0]  own_off, off1, off2;
    logic                  hit_r, hit_1, hit_2;
    logic signed [OW-1:0]  best;
    logic [IW-1:0]         pos_next;

    assign accept  = start && !busy;
    assign busy    = (r_state != malf_pkg::ST_IDLE);
    assign tr_ok   = (i_train <= 2'd2);
    assign path_ok = (32'(i_path_index) < PATH_MAX);
    assign len_sat = (32'(i_path_len) > PATH_MAX) ? CW'(PATH_MAX) : CW'(i_path_len);
    assign in_len  = tr_ok ? r_path_len[i_train] : '0;

    assign ram_we = accept && (i_op == malf_pkg::OP_PATH) && tr_ok && path_ok;
    assign waddr  = AW'(i_train) * AW'(PATH_MAX) + AW'(i_path_index);
    assign raddr  = AW'(r_t) * AW'(PATH_MAX) + AW'(rd_idx);

    malf_ram #(
        .WIDTH (BW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (waddr),
        .i_wdata (i_balise),
        .i_re    (rd_en),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    malf_walk #(
        .PATH_MAX (PATH_MAX)
    ) u_walk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (w_load),
        .i_first   (w_first),
        .i_len     (w_len),
        .i_run     (w_run),
        .o_rd_en   (rd_en),
        .o_rd_idx  (rd_idx),
        .o_tag     (tag),
        .o_tag_idx (tag_idx)
    );

    // The own train's state is stable for the whole query: busy blocks updates.
    assign t_n1    = malf_pkg::f_next(r_t);
    assign t_n2    = malf_pkg::f_next(t_n1);
    assign own_bal = r_tr_bal[r_t];
    assign own_off = r_tr_off[r_t];
    assign bal1    = r_tr_bal[t_n1];
    assign off1    = r_tr_off[t_n1];
    assign bal2    = r_tr_bal[t_n2];
    assign off2    = r_tr_off[t_n2];

    // Walk compare unit: it looks for the resource or another train and takes the
    // nearest offset; the scan matches the own balise with a compare of its own.
    assign hit_r = (rdata == r_res);
    assign hit_1 = (rdata == bal1);
    assign hit_2 = (rdata == bal2);

    always_comb begin
        best = '0;
        if (hit_1 && (!hit_r || off1 < best)) begin
            best = off1;
        end
        if (hit_2 && (!(hit_r || hit_1) || off2 < best)) begin
            best = off2;
        end
    end

    assign pos_next = ((CW'(r_pos) + CW'(1)) == r_len) ? '0 : r_pos + IW'(1);

    // Sequencer
    always_comb begin
        n_state  = r_state;
        n_pos    = r_pos;
        n_ovalid = 1'b0;
        n_obal   = r_obal;
        n_ooff   = r_ooff;
        n_ostat  = r_ostat;
        w_load   = 1'b0;
        w_first  = '0;
        w_len    = in_len;
        w_run    = 1'b0;
        case (r_state)
            malf_pkg::ST_IDLE: begin
                if (accept && i_op == malf_pkg::OP_QUERY) begin
                    if (in_len == '0) begin
                        // No such train or empty path: own balise cannot match.
                        n_ovalid = 1'b1;
                        n_obal   = '0;
                        n_ooff   = '0;
                        n_ostat  = malf_pkg::STAT_NO_OWN;
                    end else begin
                        w_load  = 1'b1;
                        n_state = malf_pkg::ST_SCAN;
                    end
                end
            end
            malf_pkg::ST_SCAN: begin
                w_run = 1'b1;
                if (tag.valid) begin
                    if (rdata == own_bal) begin
                        n_pos   = tag_idx;
                        n_state = malf_pkg::ST_SPEC;
                    end else if (tag.last) begin
                        n_ovalid = 1'b1;
                        n_obal   = '0;
                        n_ooff   = '0;
                        n_ostat  = malf_pkg::STAT_NO_OWN;
                        n_state  = malf_pkg::ST_IDLE;
                    end
                end
            end
            malf_pkg::ST_SPEC: begin
                // Same-balise cases, in priority order.
                if (r_res == own_bal && own_off <= 0) begin
                    n_ovalid = 1'b1;
                    n_obal   = r_res;
                    n_ooff   = '0;
                    n_ostat  = malf_pkg::STAT_FOUND;
                    n_state  = malf_pkg::ST_IDLE;
                end else if (bal1 == own_bal && off1 >= own_off) begin
                    n_ovalid = 1'b1;
                    n_obal   = bal1;
                    n_ooff   = off1;
                    n_ostat  = malf_pkg::STAT_FOUND;
                    n_state  = malf_pkg::ST_IDLE;
                end else if (bal2 == own_bal && off2 >= own_off) begin
                    n_ovalid = 1'b1;
                    n_obal   = bal2;
                    n_ooff   = off2;
                    n_ostat  = malf_pkg::STAT_FOUND;
                    n_state  = malf_pkg::ST_IDLE;
                end else begin
                    // Walk one lap starting just past the own entry.
                    w_load  = 1'b1;
                    w_first = pos_next;
                    w_len   = r_len;
                    n_state = malf_pkg::ST_WALK;
                end
            end
            malf_pkg::ST_WALK: begin
                w_run = 1'b1;
                if (tag.valid) begin
                    if (hit_r || hit_1 || hit_2) begin
                        n_ovalid = 1'b1;
                        n_obal   = rdata;
                        n_ooff   = best;
                        n_ostat  = malf_pkg::STAT_FOUND;
                        n_state  = malf_pkg::ST_IDLE;
                    end else if (tag.last) begin
                        n_ovalid = 1'b1;
                        n_obal   = '0;
                        n_ooff   = '0;
                        n_ostat  = malf_pkg::STAT_NO_LAP;
                        n_state  = malf_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = malf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= malf_pkg::ST_IDLE;
            r_ovalid <= 1'b0;
            for (int i = 0; i < malf_pkg::NUM_TRAINS; i++) begin
                r_path_len[i] <= '0;
                r_tr_bal[i]   <= '0;
                r_tr_off[i]   <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            if (accept && tr_ok && i_op == malf_pkg::OP_PATH) begin
                r_path_len[i_train] <= len_sat;
            end
            if (accept && tr_ok && i_op == malf_pkg::OP_POS) begin
                r_tr_bal[i_train] <= i_balise;
                r_tr_off[i_train] <= i_offset;
            end
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge i_clk) begin
        r_pos   <= n_pos;
        r_obal  <= n_obal;
        r_ooff  <= n_ooff;
        r_ostat <= n_ostat;
        if (accept && i_op == malf_pkg::OP_QUERY) begin
            r_t   <= i_train;
            r_res <= i_resource_balise;
            r_len <= in_len;
        end
    end

    assign o_valid      = r_ovalid;
    assign o_eoa_balise = r_obal;
    assign o_eoa_offset = r_ooff;
    assign o_status     = r_ostat;

    // A result only follows a query: either taken last cycle or in progress.
    a_result_from_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(r_state) != malf_pkg::ST_IDLE) ||
                    $past(start && !busy && i_op == malf_pkg::OP_QUERY))
        else $error("result without a query");

    // Failed searches carry zero balise and offset.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != malf_pkg::STAT_FOUND |->
            o_eoa_balise == '0 && o_eoa_offset == '0)
        else $error("failed search with nonzero fields");

    // Status code always meaningful.
    a_status_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == malf_pkg::STAT_FOUND ||
                     o_status == malf_pkg::STAT_NO_OWN ||
                     o_status == malf_pkg::STAT_NO_LAP))
        else $error("illegal status");

    // The own entry found by the scan lies inside the path.
    a_pos_in_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == malf_pkg::ST_WALK |-> CW'(r_pos) < r_len)
        else $error("own position outside path");

    // Memory reads happen only during scan or walk.
    a_read_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_en |-> (r_state == malf_pkg::ST_SCAN || r_state == malf_pkg::ST_WALK))
        else $error("path read outside a search");

endmodule
